FILE: sv/obm_pkg.sv
package obm_pkg;

    // configuration register width and count
    localparam int CFG_W   = 10;
    localparam int REG_N   = 8;
    localparam int IDX_W   = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_RESET_LOW      = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESENCE_SMPL  = 3'd1;
    localparam logic [IDX_W-1:0] REG_RESET_TAIL     = 3'd2;
    localparam logic [IDX_W-1:0] REG_WR_ONE_LOW     = 3'd3;
    localparam logic [IDX_W-1:0] REG_WR_ZERO_LOW    = 3'd4;
    localparam logic [IDX_W-1:0] REG_WR_ONE_HIGH    = 3'd5;
    localparam logic [IDX_W-1:0] REG_RD_SAMPLE      = 3'd6;
    localparam logic [IDX_W-1:0] REG_RD_TAIL        = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd600;
    localparam logic [CFG_W-1:0] RST_PRESENCE_SMPL = 10'd100;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd800;
    localparam logic [CFG_W-1:0] RST_WR_ONE_LOW    = 10'd8;
    localparam logic [CFG_W-1:0] RST_WR_ZERO_LOW   = 10'd80;
    localparam logic [CFG_W-1:0] RST_WR_ONE_HIGH   = 10'd80;
    localparam logic [CFG_W-1:0] RST_RD_SAMPLE     = 10'd5;
    localparam logic [CFG_W-1:0] RST_RD_TAIL       = 10'd60;

    // fixed slot timings
    localparam logic [CFG_W-1:0] WR_ZERO_HIGH_TICKS = 10'd2;
    localparam logic [CFG_W-1:0] RD_LOW_TICKS       = 10'd2;

    // command codes
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // stream widths
    localparam int DATA_W = 16;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_us;
        logic [CFG_W-1:0] presence_sample_us;
        logic [CFG_W-1:0] reset_tail_us;
        logic [CFG_W-1:0] write_one_low_us;
        logic [CFG_W-1:0] write_zero_low_us;
        logic [CFG_W-1:0] write_one_high_us;
        logic [CFG_W-1:0] read_sample_us;
        logic [CFG_W-1:0] read_tail_us;
    } t_cfg;

    typedef struct packed {
        logic       line_level;
        logic [7:0] write_data;
        logic [1:0] operation;
        logic       start_req;
    } t_tick;

    typedef struct packed {
        logic       no_device;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_result;

endpackage

FILE: sv/onewire_bus_master_unit.sv
// 1-wire bus master, stepped by one input beat per microsecond tick. each beat
// on the slave stream carries a start request, the command (reset and presence,
// write byte, read byte), the byte to write and the sampled wire level; each
// beat returns exactly one result beat with the drive-low request for that
// tick, busy, a one-tick done pulse, the last read byte and the no-device flag.
// a start is taken only when idle; command code 3 is ignored. slot timings sit
// in eight 10-bit registers written through the cfg channel (always ready),
// meant to be written while no command runs; durations saturate to the
// TIMER_BITS counter and a zero setting gives one tick. throughput is one beat
// per clock while the master side does not stall; each beat passes through the
// input register and then the result register, with the phase machine
// working in a single pass between them. back-pressure on the master side
// holds the whole pipeline.
module onewire_bus_master_unit #(
    parameter int TIMER_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] start_req, [2:1] operation, [10:3] write_data, [11] line_level
    input  logic [obm_pkg::DATA_W-1:0]        s_axis_tdata,
    // result stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_byte, [11] no_device
    output logic [obm_pkg::DATA_W-1:0]        m_axis_tdata,
    // register write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [obm_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [obm_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int TICK_W = $bits(obm_pkg::t_tick);
    localparam int RES_W  = $bits(obm_pkg::t_result);

    obm_pkg::t_cfg    w_cfg;
    obm_pkg::t_result w_res;

    logic             r_in_valid;
    obm_pkg::t_tick   r_in_tick;
    logic             r_out_valid;
    obm_pkg::t_result r_out_res;

    // result register free or being drained this cycle
    logic w_out_adv;
    // one tick processed: state of the bus master moves on
    logic w_step;

    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_adv;
    assign s_axis_tready = !r_in_valid || w_out_adv;
    assign o_cfg_ready   = 1'b1;

    obm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_tick <= s_axis_tdata[TICK_W-1:0];
        end
    end

    obm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_tick  (r_in_tick),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = obm_pkg::DATA_W'(r_out_res);

    // only RES_W result bits are live, upper beat bits are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[obm_pkg::DATA_W-1:RES_W] == '0))
        else $error("result padding not zero");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("processed tick lost before the result register");

    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_adv) |=> (r_in_valid && $stable(r_in_tick)))
        else $error("pending tick dropped during a stall");

endmodule

FILE: sv/obm_regs.sv
module obm_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [obm_pkg::IDX_W-1:0]        i_wr_index,
    input  logic [obm_pkg::CFG_W-1:0]        i_wr_data,
    output obm_pkg::t_cfg                    o_cfg
);

    obm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us       <= obm_pkg::RST_RESET_LOW;
            r_cfg.presence_sample_us <= obm_pkg::RST_PRESENCE_SMPL;
            r_cfg.reset_tail_us      <= obm_pkg::RST_RESET_TAIL;
            r_cfg.write_one_low_us   <= obm_pkg::RST_WR_ONE_LOW;
            r_cfg.write_zero_low_us  <= obm_pkg::RST_WR_ZERO_LOW;
            r_cfg.write_one_high_us  <= obm_pkg::RST_WR_ONE_HIGH;
            r_cfg.read_sample_us     <= obm_pkg::RST_RD_SAMPLE;
            r_cfg.read_tail_us       <= obm_pkg::RST_RD_TAIL;
        end else if (i_wr_en) begin
            case (i_wr_index)
                obm_pkg::REG_RESET_LOW:     r_cfg.reset_low_us       <= i_wr_data;
                obm_pkg::REG_PRESENCE_SMPL: r_cfg.presence_sample_us <= i_wr_data;
                obm_pkg::REG_RESET_TAIL:    r_cfg.reset_tail_us      <= i_wr_data;
                obm_pkg::REG_WR_ONE_LOW:    r_cfg.write_one_low_us   <= i_wr_data;
                obm_pkg::REG_WR_ZERO_LOW:   r_cfg.write_zero_low_us  <= i_wr_data;
                obm_pkg::REG_WR_ONE_HIGH:   r_cfg.write_one_high_us  <= i_wr_data;
                obm_pkg::REG_RD_SAMPLE:     r_cfg.read_sample_us     <= i_wr_data;
                obm_pkg::REG_RD_TAIL:       r_cfg.read_tail_us       <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/obm_core.sv
module obm_core #(
    parameter int TIMER_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  obm_pkg::t_tick    i_tick,
    input  obm_pkg::t_cfg     i_cfg,
    output obm_pkg::t_result  o_res
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_HIGH  = 4'd5;
    localparam logic [3:0] PH_RD_LOW   = 4'd6;
    localparam logic [3:0] PH_RD_WAIT  = 4'd7;
    localparam logic [3:0] PH_RD_TAIL  = 4'd8;

    localparam int EXT_W = TIMER_BITS + obm_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    // saturate to the timer range, zero means one tick
    function automatic logic [TIMER_BITS-1:0] f_load(input logic [obm_pkg::CFG_W-1:0] ticks);
        logic [EXT_W-1:0]      ext;
        logic [TIMER_BITS-1:0] t;
        ext = EXT_W'(ticks);
        if (ext > EXT_W'(TMAX)) begin
            t = TMAX;
        end else begin
            t = ext[TIMER_BITS-1:0];
        end
        if (t == '0) begin
            t = TIMER_BITS'(1);
        end
        return t;
    endfunction

    logic [3:0]            r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [2:0]            r_bit, n_bit;
    logic [7:0]            r_shift, n_shift;
    logic                  r_pres_missing, n_pres_missing;
    logic [7:0]            r_read_hold, n_read_hold;
    logic                  n_drive;
    logic                  n_done;

    always_comb begin
        n_phase        = r_phase;
        n_timer        = r_timer;
        n_bit          = r_bit;
        n_shift        = r_shift;
        n_pres_missing = r_pres_missing;
        n_read_hold    = r_read_hold;
        n_drive        = 1'b0;
        n_done         = 1'b0;

        // command start, first phase counts this tick
        if (r_phase == PH_IDLE && i_tick.start_req && i_tick.operation != obm_pkg::OP_NONE) begin
            n_bit = '0;
            case (i_tick.operation)
                obm_pkg::OP_RESET: begin
                    n_phase = PH_RST_LOW;
                    n_timer = f_load(i_cfg.reset_low_us);
                end
                obm_pkg::OP_WRITE: begin
                    n_shift = i_tick.write_data;
                    n_phase = PH_WR_LOW;
                    n_timer = f_load(i_tick.write_data[0] ? i_cfg.write_one_low_us
                                                          : i_cfg.write_zero_low_us);
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_RD_LOW;
                    n_timer = f_load(obm_pkg::RD_LOW_TICKS);
                end
            endcase
        end

        if (n_phase != PH_IDLE) begin
            n_drive = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW) ||
                      (n_phase == PH_RD_LOW);
            if (n_timer > TIMER_BITS'(1)) begin
                n_timer = n_timer - TIMER_BITS'(1);
            end else begin
                n_timer = '0;
                case (n_phase)
                    PH_RST_LOW: begin
                        n_phase = PH_RST_WAIT;
                        n_timer = f_load(i_cfg.presence_sample_us);
                    end
                    PH_RST_WAIT: begin
                        n_pres_missing = i_tick.line_level;
                        n_phase        = PH_RST_TAIL;
                        n_timer        = f_load(i_cfg.reset_tail_us);
                    end
                    PH_WR_LOW: begin
                        n_phase = PH_WR_HIGH;
                        n_timer = f_load(n_shift[0] ? i_cfg.write_one_high_us
                                                    : obm_pkg::WR_ZERO_HIGH_TICKS);
                    end
                    PH_WR_HIGH: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        if (n_bit == 3'd7) begin
                            n_bit   = '0;
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = PH_WR_LOW;
                            n_timer = f_load(n_shift[0] ? i_cfg.write_one_low_us
                                                        : i_cfg.write_zero_low_us);
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase = PH_RD_WAIT;
                        n_timer = f_load(i_cfg.read_sample_us);
                    end
                    PH_RD_WAIT: begin
                        n_shift = {i_tick.line_level, n_shift[7:1]};
                        n_phase = PH_RD_TAIL;
                        n_timer = f_load(i_cfg.read_tail_us);
                    end
                    PH_RD_TAIL: begin
                        if (n_bit == 3'd7) begin
                            n_bit       = '0;
                            n_read_hold = n_shift;
                            n_phase     = PH_IDLE;
                            n_done      = 1'b1;
                        end else begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = PH_RD_LOW;
                            n_timer = f_load(obm_pkg::RD_LOW_TICKS);
                        end
                    end
                    default: begin
                        // reset tail ends the command
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_timer        <= '0;
            r_bit          <= '0;
            r_shift        <= '0;
            r_pres_missing <= 1'b0;
            r_read_hold    <= '0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_timer        <= n_timer;
            r_bit          <= n_bit;
            r_shift        <= n_shift;
            r_pres_missing <= n_pres_missing;
            r_read_hold    <= n_read_hold;
        end
    end

    assign o_res.drive_low = n_drive;
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.done_res  = n_done;
    assign o_res.read_byte = n_read_hold;
    assign o_res.no_device = n_pres_missing;

    a_busy_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_timer != '0))
        else $error("active phase with an expired timer");

    a_idle_bit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bit == '0))
        else $error("bit counter left over in idle");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && n_done) |=> (r_phase == PH_IDLE))
        else $error("completion without return to idle");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && n_drive) |-> (n_phase != PH_IDLE))
        else $error("wire driven low on the last tick of a command");

endmodule
